// ===== hw/rtl/drp_pkg.sv =====
// Shared types and codes for the digraph reachability path unit.
// Used by digraph_reachability_path_unit and drp_checker; no dependencies.
`timescale 1ns / 1ps

package drp_pkg;

  localparam int VtxW  = 5;
  localparam int CntW  = 6;
  localparam int StatW = 2;

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  // result status codes
  localparam logic [StatW-1:0] ST_ACK     = 2'd0;
  localparam logic [StatW-1:0] ST_PATH    = 2'd1;
  localparam logic [StatW-1:0] ST_NO_PATH = 2'd2;
  localparam logic [StatW-1:0] ST_INVALID = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EDGE = 8'b0000_0010,
    S_SRCH = 8'b0000_0100,
    S_POP  = 8'b0000_1000,
    S_WALK = 8'b0001_0000,
    S_WAIT = 8'b0010_0000,
    S_ERD  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

endpackage

// ===== hw/rtl/digraph_reachability_path_unit.sv =====
// Digraph reachability unit: adjacency memory, depth-first search, path report.
// Depends on drp_pkg.
`timescale 1ns / 1ps

// Keeps a directed graph as an adjacency bit matrix in a synchronous memory.
// Add-edge, clear and reserved requests answer with one result; clear takes
// effect at once through per-row valid bits.
// A path query runs a depth-first search: each descent is one row read, each
// backtrack a stack read then a row read; the search stops as soon as the
// target is discovered. The path is then rebuilt from the parent memory, one
// parent read per edge, and sent out one vertex per stack read. Backtracks
// only happen on vertices off the final path. busy stays high until the last
// result has been put on the ports; results appear as one-cycle strobes on
// out_valid and cannot be held off.
module digraph_reachability_path_unit #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_req_type,
  input  logic [drp_pkg::VtxW-1:0]  in_from_vertex,
  input  logic [drp_pkg::VtxW-1:0]  in_to_vertex,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [drp_pkg::CntW-1:0]  cfg_vertex_count,
  output logic                      out_valid,
  output logic [drp_pkg::StatW-1:0] out_status,
  output logic [drp_pkg::VtxW-1:0]  out_path_vertex,
  output logic [drp_pkg::VtxW-1:0]  out_distance,
  output logic                      out_last
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DW = $clog2(MAX_VERTICES + 1);
  localparam int NW = drp_pkg::CntW + 1;

  // memories
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [VW-1:0]           par_mem [MAX_VERTICES];
  logic [VW-1:0]           scr_mem [MAX_VERTICES];

  logic                    adj_we, par_we, scr_we;
  logic [VW-1:0]           adj_waddr, adj_raddr, par_waddr, par_raddr;
  logic [VW-1:0]           scr_waddr, scr_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [VW-1:0]           par_wdata, scr_wdata;
  logic [MAX_VERTICES-1:0] adj_q;
  logic                    adj_qvld;
  logic [VW-1:0]           par_q, scr_q;

  // control registers
  drp_pkg::state_t         state_r, state_nxt;
  logic [drp_pkg::CntW-1:0] cnt_r;
  logic [MAX_VERTICES-1:0] row_vld_r, row_vld_nxt;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;
  logic [VW-1:0]           src_r, src_nxt, tgt_r, tgt_nxt;
  logic [VW-1:0]           cur_r, cur_nxt;
  logic [DW-1:0]           sp_r, sp_nxt;
  logic [drp_pkg::VtxW-1:0] dist_r, dist_nxt;

  // output registers
  logic                     ov_r, ov_nxt;
  logic [drp_pkg::StatW-1:0] ost_r, ost_nxt;
  logic [drp_pkg::VtxW-1:0] ovx_r, ovx_nxt, odi_r, odi_nxt;
  logic                     olast_r, olast_nxt;

  logic [NW-1:0]           n_eff;
  logic [MAX_VERTICES-1:0] nmask, row, cand;
  logic [VW-1:0]           low_idx;
  logic [VW-1:0]           in_s, in_t;
  logic                    accept, in_bad;

  function automatic logic [VW-1:0] lowest(input logic [MAX_VERTICES-1:0] v);
    logic [VW-1:0] idx;
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (v[i]) idx = VW'(i);
    end
    return idx;
  endfunction

  // effective vertex count and mask of vertices in use
  always_comb begin
    n_eff = (NW'(cnt_r) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(cnt_r);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      nmask[i] = (NW'(i) < n_eff);
    end
  end

  assign in_s    = VW'(in_from_vertex);
  assign in_t    = VW'(in_to_vertex);
  assign in_bad  = (NW'(in_from_vertex) >= n_eff) || (NW'(in_to_vertex) >= n_eff);
  assign accept  = start && !busy;
  assign row     = adj_qvld ? adj_q : '0;
  assign cand    = row & ~vis_r & nmask;
  assign low_idx = lowest(cand);

  // adjacency memory, row valid looked up with the read
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_q    <= adj_mem[adj_raddr];
    adj_qvld <= row_vld_nxt[adj_raddr] && row_vld_r[adj_raddr];
  end

  // parent memory
  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_q <= par_mem[par_raddr];
  end

  // scratch memory: search stack during the search, reverse path afterwards
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    scr_q <= scr_mem[scr_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    row_vld_nxt = row_vld_r;
    vis_nxt     = vis_r;
    src_nxt     = src_r;
    tgt_nxt     = tgt_r;
    cur_nxt     = cur_r;
    sp_nxt      = sp_r;
    dist_nxt    = dist_r;
    ov_nxt      = 1'b0;
    ost_nxt     = drp_pkg::ST_ACK;
    ovx_nxt     = '0;
    odi_nxt     = '0;
    olast_nxt   = 1'b1;
    adj_we      = 1'b0;
    adj_waddr   = src_r;
    adj_wdata   = '0;
    adj_raddr   = in_s;
    par_we      = 1'b0;
    par_waddr   = low_idx;
    par_wdata   = cur_r;
    par_raddr   = cur_r;
    scr_we      = 1'b0;
    scr_waddr   = sp_r[VW-1:0];
    scr_wdata   = cur_r;
    scr_raddr   = VW'(sp_r - DW'(1));
    case (state_r)
      drp_pkg::S_IDLE: begin
        if (accept) begin
          src_nxt = in_s;
          tgt_nxt = in_t;
          ov_nxt  = 1'b1;
          if (in_req_type == drp_pkg::REQ_CLEAR) begin
            row_vld_nxt = '0;
          end else if (in_req_type != drp_pkg::REQ_ADD &&
                       in_req_type != drp_pkg::REQ_QUERY) begin
            ost_nxt = drp_pkg::ST_ACK;
          end else if (in_bad) begin
            ost_nxt = drp_pkg::ST_INVALID;
          end else if (in_req_type == drp_pkg::REQ_ADD) begin
            ov_nxt    = 1'b0;
            state_nxt = drp_pkg::S_EDGE;
          end else if (in_s == in_t) begin
            ost_nxt = drp_pkg::ST_PATH;
            ovx_nxt = in_from_vertex;
          end else begin
            ov_nxt    = 1'b0;
            vis_nxt   = '0;
            vis_nxt[in_s] = 1'b1;
            cur_nxt   = in_s;
            sp_nxt    = '0;
            state_nxt = drp_pkg::S_SRCH;
          end
        end
      end
      drp_pkg::S_EDGE: begin
        adj_we    = 1'b1;
        adj_waddr = src_r;
        adj_wdata = row;
        adj_wdata[tgt_r] = 1'b1;
        row_vld_nxt[src_r] = 1'b1;
        ov_nxt    = 1'b1;
        state_nxt = drp_pkg::S_IDLE;
      end
      drp_pkg::S_SRCH: begin
        if (cand != '0) begin
          // descend into the lowest unvisited neighbor
          scr_we    = 1'b1;
          par_we    = 1'b1;
          sp_nxt    = sp_r + DW'(1);
          vis_nxt[low_idx] = 1'b1;
          cur_nxt   = low_idx;
          adj_raddr = low_idx;
          if (low_idx == tgt_r) begin
            sp_nxt    = '0;
            state_nxt = drp_pkg::S_WALK;
          end
        end else if (sp_r == '0) begin
          ov_nxt    = 1'b1;
          ost_nxt   = drp_pkg::ST_NO_PATH;
          state_nxt = drp_pkg::S_IDLE;
        end else begin
          sp_nxt    = sp_r - DW'(1);
          state_nxt = drp_pkg::S_POP;
        end
      end
      drp_pkg::S_POP: begin
        cur_nxt   = scr_q;
        adj_raddr = scr_q;
        state_nxt = drp_pkg::S_SRCH;
      end
      drp_pkg::S_WALK: begin
        if (cur_r == src_r) begin
          ov_nxt    = 1'b1;
          ost_nxt   = drp_pkg::ST_PATH;
          ovx_nxt   = drp_pkg::VtxW'(src_r);
          olast_nxt = (sp_r == '0);
          dist_nxt  = drp_pkg::VtxW'(1);
          state_nxt = (sp_r == '0) ? drp_pkg::S_IDLE : drp_pkg::S_ERD;
        end else begin
          // push onto the reverse path and fetch the parent
          scr_we    = 1'b1;
          sp_nxt    = sp_r + DW'(1);
          par_raddr = cur_r;
          state_nxt = drp_pkg::S_WAIT;
        end
      end
      drp_pkg::S_WAIT: begin
        cur_nxt   = par_q;
        state_nxt = drp_pkg::S_WALK;
      end
      drp_pkg::S_ERD: begin
        sp_nxt    = sp_r - DW'(1);
        state_nxt = drp_pkg::S_EMIT;
      end
      drp_pkg::S_EMIT: begin
        ov_nxt    = 1'b1;
        ost_nxt   = drp_pkg::ST_PATH;
        ovx_nxt   = drp_pkg::VtxW'(scr_q);
        odi_nxt   = dist_r;
        olast_nxt = (sp_r == '0);
        dist_nxt  = dist_r + drp_pkg::VtxW'(1);
        state_nxt = (sp_r == '0) ? drp_pkg::S_IDLE : drp_pkg::S_ERD;
      end
      default: begin
        state_nxt = drp_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= drp_pkg::S_IDLE;
      cnt_r     <= drp_pkg::CntW'(32);
      row_vld_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_vld_r <= row_vld_nxt;
      ov_r      <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        cnt_r <= cfg_vertex_count;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    vis_r   <= vis_nxt;
    src_r   <= src_nxt;
    tgt_r   <= tgt_nxt;
    cur_r   <= cur_nxt;
    sp_r    <= sp_nxt;
    dist_r  <= dist_nxt;
    ost_r   <= ost_nxt;
    ovx_r   <= ovx_nxt;
    odi_r   <= odi_nxt;
    olast_r <= olast_nxt;
  end

  assign busy            = (state_r != drp_pkg::S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_path_vertex = ovx_r;
  assign out_distance    = odi_r;
  assign out_last        = olast_r;

endmodule

// ===== hw/rtl/drp_checker.sv =====
// Port-level checks for digraph_reachability_path_unit, bound to the top level.
// Depends on drp_pkg.
`timescale 1ns / 1ps

module drp_port_checks (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [drp_pkg::StatW-1:0] out_status,
  input logic [drp_pkg::VtxW-1:0]  out_path_vertex,
  input logic [drp_pkg::VtxW-1:0]  out_distance,
  input logic                      out_last
);

  // only path results can leave more to come
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != drp_pkg::ST_PATH |-> out_last)
    else $error("non-path result without last");

  // non-path results carry zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != drp_pkg::ST_PATH |->
      out_path_vertex == '0 && out_distance == '0)
    else $error("non-path result with payload");

  // more results pending keeps the unit busy
  a_busy_mid_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("idle while path incomplete");

  // a path result not last is followed by a gap
  a_path_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> !out_valid)
    else $error("back to back path results");

  // reset silences the output
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind digraph_reachability_path_unit drp_port_checks u_drp_port_checks (.*);
